>>> src/dlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete logarithm package
// Shared command and status types and the hash constant of the baby-step table.
// ----------------------------------------------------------------------------
package dlb_pkg;

    typedef enum logic [1:0] {
        MM_REDUCE = 2'b01,
        MM_MUL    = 2'b10
    } mm_op_t;

    typedef enum logic [2:0] {
        TBL_CLEAR = 3'b001,
        TBL_PUT   = 3'b010,
        TBL_GET   = 3'b100
    } tbl_op_t;

    typedef struct packed {
        logic   start;
        mm_op_t op;
    } mm_cmd_t;

    typedef struct packed {
        logic    start;
        tbl_op_t op;
    } tbl_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } tbl_sts_t;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

endpackage

>>> src/dlb_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial modular unit
// Computes x mod p or x*y mod p one bit a cycle with a shift, add and subtract.
// ----------------------------------------------------------------------------
module dlb_modmul #(
    parameter int MOD_BITS = 31,
    parameter int XW       = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dlb_pkg::mm_cmd_t    cmd,
    input  logic [XW-1:0]       x,
    input  logic [MOD_BITS-1:0] y,
    input  logic [MOD_BITS-1:0] p,
    output logic                done,
    output logic [MOD_BITS-1:0] res
);
    localparam int CW = $clog2(XW);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    dlb_pkg::mm_op_t     op_reg, op_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [XW-1:0]       shf_reg, shf_next;
    logic [MOD_BITS-1:0] add_reg, add_next;
    logic [MOD_BITS-1:0] p_reg, p_next;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic                cur_bit;
    logic [MOD_BITS:0]   sh, t, u, v;

    always_comb begin
        cur_bit = shf_reg[cnt_reg];
        sh = {r_reg, (op_reg == dlb_pkg::MM_REDUCE) & cur_bit};
        t  = (sh >= {1'b0, p_reg}) ? sh - {1'b0, p_reg} : sh;
        u  = {1'b0, t[MOD_BITS-1:0]}
           + (((op_reg == dlb_pkg::MM_MUL) && cur_bit) ? {1'b0, add_reg} : '0);
        v  = (u >= {1'b0, p_reg}) ? u - {1'b0, p_reg} : u;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        shf_next  = shf_reg;
        add_next  = add_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        if (cmd.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            p_next    = p;
            r_next    = '0;
            if (cmd.op == dlb_pkg::MM_REDUCE) begin
                cnt_next = CW'(XW - 1);
                shf_next = x;
                add_next = '0;
            end else begin
                cnt_next = CW'(MOD_BITS - 1);
                shf_next = XW'(y);
                add_next = x[MOD_BITS-1:0];
            end
        end else if (busy_reg) begin
            r_next = v[MOD_BITS-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        shf_reg <= shf_next;
        add_reg <= add_next;
        p_reg   <= p_next;
        r_reg   <= r_next;
    end

    assign done = done_reg;
    assign res  = r_reg;

endmodule

>>> src/dlb_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Baby-step hash table
// Open-addressed table with linear probing, one probe a cycle; the depth must be
// a power of two, which the block does not check.
// ----------------------------------------------------------------------------
module dlb_table #(
    parameter int MOD_BITS    = 31,
    parameter int TABLE_DEPTH = 65536,
    parameter int IDX_W       = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dlb_pkg::tbl_cmd_t   cmd,
    input  logic [MOD_BITS-1:0] key,
    input  logic [IDX_W-1:0]    idx,
    output dlb_pkg::tbl_sts_t   sts,
    output logic [IDX_W-1:0]    j
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = 1 + MOD_BITS + IDX_W;

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_CLR   = 3'b010,
        T_PROBE = 3'b100
    } tstate_t;

    logic [DW-1:0]       mem [TABLE_DEPTH];
    logic [DW-1:0]       rd_reg;
    tstate_t             state_reg, state_next;
    dlb_pkg::tbl_op_t    op_reg, op_next;
    logic [MOD_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       n_reg, n_next;
    logic                done_reg, done_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [31:0]         key32;
    logic [2*AW-1:0]     hp;
    logic [AW-1:0]       home, slot_inc, rd_addr, wa;
    logic                we;
    logic [DW-1:0]       wd;
    logic                rd_valid, match;

    assign key32    = 32'(key);
    assign hp       = key32[AW-1:0] * dlb_pkg::HASH_MULT[AW-1:0];
    assign home     = hp[AW-1:0];
    assign slot_inc = slot_reg + AW'(1);
    assign rd_addr  = (state_reg == T_IDLE) ? home : slot_inc;
    assign rd_valid = rd_reg[DW-1];
    assign match    = rd_valid && (rd_reg[DW-2:IDX_W] == key_reg);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        j_next     = j_reg;
        we         = 1'b0;
        wa         = slot_reg;
        wd         = '0;
        unique case (state_reg)
            T_IDLE: begin
                if (cmd.start) begin
                    op_next  = cmd.op;
                    key_next = key;
                    idx_next = idx;
                    n_next   = '0;
                    if (cmd.op == dlb_pkg::TBL_CLEAR) begin
                        slot_next  = '0;
                        state_next = T_CLR;
                    end else begin
                        slot_next  = home;
                        state_next = T_PROBE;
                    end
                end
            end
            T_CLR: begin
                we = 1'b1;
                if (slot_reg == AW'(TABLE_DEPTH - 1)) begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = T_IDLE;
                end else begin
                    slot_next = slot_inc;
                end
            end
            T_PROBE: begin
                if (op_reg == dlb_pkg::TBL_PUT && (!rd_valid || match)) begin
                    we         = 1'b1;
                    wd         = {1'b1, key_reg, idx_reg};
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = T_IDLE;
                end else if (op_reg == dlb_pkg::TBL_GET && !rd_valid) begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = T_IDLE;
                end else if (op_reg == dlb_pkg::TBL_GET && match) begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    j_next     = rd_reg[IDX_W-1:0];
                    state_next = T_IDLE;
                end else if (n_reg == AW'(TABLE_DEPTH - 1)) begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = T_IDLE;
                end else begin
                    slot_next = slot_inc;
                    n_next    = n_reg + AW'(1);
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        n_reg    <= n_next;
        hit_reg  <= hit_next;
        j_reg    <= j_next;
    end

    assign sts.done = done_reg;
    assign sts.hit  = hit_reg;
    assign j        = j_reg;

endmodule

>>> src/discrete_log_bsgs_unit.sv
`timescale 1ns / 1ps
// Special cases skip the search; a full solve runs its baby and giant steps with m = ceil(sqrt(p)).
// Throughput: one query at a time, set by the bit-serial modular unit and the table probes.
// Reset clears the control state; the table memory is not reset but swept clear
// before the baby steps of every query that reaches them.
// ----------------------------------------------------------------------------
// Discrete logarithm unit
// Solves a^x = b (mod p) by baby-step giant-step under a small sequencer.
// ----------------------------------------------------------------------------
module discrete_log_bsgs_unit #(
    parameter int  MOD_BITS    = 31,
    parameter int  TABLE_DEPTH = 65536,
    localparam int S_TDATA_W   = ((3 * MOD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((MOD_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // modulus, base, target, zero padding
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // exponent, zero padding
    output logic                 m_tuser   // found
);
    localparam int SQ_W = (MOD_BITS + 1) / 2 + 1;
    localparam int XW   = 2 * SQ_W;
    localparam int KW   = $clog2(SQ_W);

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_RED_A     = 19'h00002,
        S_RED_B     = 19'h00004,
        S_CHECK     = 19'h00008,
        S_SQRT_MUL  = 19'h00010,
        S_SQRT_CMP  = 19'h00020,
        S_SQFIX_MUL = 19'h00040,
        S_SQFIX_CMP = 19'h00080,
        S_CLEAR     = 19'h00100,
        S_BABY_PUT  = 19'h00200,
        S_BABY_MUL  = 19'h00400,
        S_POW_SQ    = 19'h00800,
        S_POW_MUL   = 19'h01000,
        S_GIANT_MUL = 19'h02000,
        S_GIANT_GET = 19'h04000,
        S_EXP_MUL   = 19'h08000,
        S_EXP_SUB   = 19'h10000,
        S_EXP_RED   = 19'h20000,
        S_OUT       = 19'h40000
    } state_t;

    state_t              state_reg, state_next;
    logic                iss_reg, iss_next;
    logic                mv_reg, mv_next;
    logic [MOD_BITS-1:0] p_reg, p_next, a_reg, a_next, b_reg, b_next;
    logic [MOD_BITS-1:0] tmp_reg, tmp_next, acc_reg, acc_next, g_reg, g_next;
    logic [SQ_W-1:0]     root_reg, root_next, m_reg, m_next, i_reg, i_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [XW-1:0]       prod_reg, prod_next, diff_reg, diff_next;
    logic                fnd_reg, fnd_next, mf_reg, mf_next;
    logic [MOD_BITS-1:0] xr_reg, xr_next, me_reg, me_next;

    logic [MOD_BITS-1:0] in_mod, in_base, in_tgt;
    dlb_pkg::mm_cmd_t    mm_cmd;
    logic [XW-1:0]       mm_x;
    logic [MOD_BITS-1:0] mm_y, mm_res;
    logic                mm_done;
    dlb_pkg::tbl_cmd_t   tbl_cmd;
    logic [MOD_BITS-1:0] tbl_key;
    dlb_pkg::tbl_sts_t   tbl_sts;
    logic [SQ_W-1:0]     tbl_j;
    logic [SQ_W-1:0]     mul_x, mul_y, cand;
    logic [XW-1:0]       mul_p;
    logic [MOD_BITS-1:0] pow_val;
    logic                pow_last;

    assign in_mod  = s_tdata[MOD_BITS-1:0];
    assign in_base = s_tdata[2*MOD_BITS-1:MOD_BITS];
    assign in_tgt  = s_tdata[3*MOD_BITS-1:2*MOD_BITS];
    assign cand    = root_reg | (SQ_W'(1) << k_reg);
    assign mul_p   = mul_x * mul_y;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        tmp_next   = tmp_reg;
        acc_next   = acc_reg;
        g_next     = g_reg;
        root_next  = root_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        diff_next  = diff_reg;
        fnd_next   = fnd_reg;
        xr_next    = xr_reg;
        mf_next    = mf_reg;
        me_next    = me_reg;
        mm_cmd     = '{start: 1'b0, op: dlb_pkg::MM_MUL};
        mm_x       = XW'(acc_reg);
        mm_y       = acc_reg;
        tbl_cmd    = '{start: 1'b0, op: dlb_pkg::TBL_GET};
        tbl_key    = acc_reg;
        mul_x      = cand;
        mul_y      = cand;
        pow_val    = mm_res;
        pow_last   = 1'b0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    p_next = in_mod;
                    a_next = in_base;
                    b_next = in_tgt;
                    if (in_mod == '0) begin
                        fnd_next   = 1'b0;
                        xr_next    = '0;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_REDUCE};
                mm_x   = XW'(a_reg);
                if (mm_done) begin
                    a_next     = mm_res;
                    state_next = S_RED_B;
                end
            end
            S_RED_B: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_REDUCE};
                mm_x   = XW'(b_reg);
                if (mm_done) begin
                    b_next     = mm_res;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (a_reg == '0 && b_reg == '0) begin
                    fnd_next   = 1'b1;
                    xr_next    = (p_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    state_next = S_OUT;
                end else if (a_reg == '0) begin
                    fnd_next   = 1'b0;
                    xr_next    = '0;
                    state_next = S_OUT;
                end else begin
                    root_next  = '0;
                    k_next     = KW'(SQ_W - 1);
                    state_next = S_SQRT_MUL;
                end
            end
            S_SQRT_MUL: begin
                prod_next  = mul_p;
                state_next = S_SQRT_CMP;
            end
            S_SQRT_CMP: begin
                if (prod_reg <= XW'(p_reg)) begin
                    root_next = cand;
                end
                if (k_reg == '0) begin
                    state_next = S_SQFIX_MUL;
                end else begin
                    k_next     = k_reg - KW'(1);
                    state_next = S_SQRT_MUL;
                end
            end
            S_SQFIX_MUL: begin
                mul_x      = root_reg;
                mul_y      = root_reg;
                prod_next  = mul_p;
                state_next = S_SQFIX_CMP;
            end
            S_SQFIX_CMP: begin
                m_next     = (prod_reg < XW'(p_reg)) ? root_reg + SQ_W'(1) : root_reg;
                state_next = S_CLEAR;
            end
            S_CLEAR: begin
                tbl_cmd = '{start: !iss_reg, op: dlb_pkg::TBL_CLEAR};
                if (tbl_sts.done) begin
                    i_next     = '0;
                    tmp_next   = b_reg;
                    state_next = S_BABY_PUT;
                end
            end
            S_BABY_PUT: begin
                tbl_cmd = '{start: !iss_reg, op: dlb_pkg::TBL_PUT};
                tbl_key = tmp_reg;
                if (tbl_sts.done) begin
                    if (i_reg == m_reg) begin
                        acc_next   = MOD_BITS'(1);
                        k_next     = KW'(SQ_W - 1);
                        state_next = S_POW_SQ;
                    end else begin
                        state_next = S_BABY_MUL;
                    end
                end
            end
            S_BABY_MUL: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_MUL};
                mm_x   = XW'(tmp_reg);
                mm_y   = a_reg;
                if (mm_done) begin
                    tmp_next   = mm_res;
                    i_next     = i_reg + SQ_W'(1);
                    state_next = S_BABY_PUT;
                end
            end
            S_POW_SQ: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_MUL};
                if (mm_done) begin
                    acc_next = mm_res;
                    if (m_reg[k_reg]) begin
                        state_next = S_POW_MUL;
                    end else begin
                        pow_last = 1'b1;
                    end
                end
            end
            S_POW_MUL: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_MUL};
                mm_x   = XW'(a_reg);
                if (mm_done) begin
                    acc_next = mm_res;
                    pow_last = 1'b1;
                end
            end
            S_GIANT_MUL: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_MUL};
                mm_x   = XW'(g_reg);
                if (mm_done) begin
                    acc_next   = mm_res;
                    state_next = S_GIANT_GET;
                end
            end
            S_GIANT_GET: begin
                tbl_cmd = '{start: !iss_reg, op: dlb_pkg::TBL_GET};
                if (tbl_sts.done) begin
                    if (tbl_sts.hit) begin
                        state_next = S_EXP_MUL;
                    end else if (i_reg == m_reg + SQ_W'(1)) begin
                        fnd_next   = 1'b0;
                        xr_next    = '0;
                        state_next = S_OUT;
                    end else begin
                        i_next     = i_reg + SQ_W'(1);
                        state_next = S_GIANT_MUL;
                    end
                end
            end
            S_EXP_MUL: begin
                mul_x      = i_reg;
                mul_y      = m_reg;
                prod_next  = mul_p;
                state_next = S_EXP_SUB;
            end
            S_EXP_SUB: begin
                diff_next  = prod_reg - XW'(tbl_j);
                state_next = S_EXP_RED;
            end
            S_EXP_RED: begin
                mm_cmd = '{start: !iss_reg, op: dlb_pkg::MM_REDUCE};
                mm_x   = diff_reg;
                if (mm_done) begin
                    fnd_next   = 1'b1;
                    xr_next    = mm_res;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mf_next    = fnd_reg;
                    me_next    = xr_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (pow_last) begin
            if (k_reg == '0) begin
                g_next     = pow_val;
                acc_next   = MOD_BITS'(1);
                i_next     = SQ_W'(1);
                state_next = S_GIANT_MUL;
            end else begin
                k_next     = k_reg - KW'(1);
                state_next = S_POW_SQ;
            end
        end
        iss_next = (iss_reg | mm_cmd.start | tbl_cmd.start) & !(mm_done | tbl_sts.done);
    end

    dlb_modmul #(
        .MOD_BITS (MOD_BITS),
        .XW       (XW)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mm_cmd),
        .x       (mm_x),
        .y       (mm_y),
        .p       (p_reg),
        .done    (mm_done),
        .res     (mm_res)
    );

    dlb_table #(
        .MOD_BITS    (MOD_BITS),
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (SQ_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tbl_cmd),
        .key     (tbl_key),
        .idx     (i_reg),
        .sts     (tbl_sts),
        .j       (tbl_j)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iss_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        tmp_reg  <= tmp_next;
        acc_reg  <= acc_next;
        g_reg    <= g_next;
        root_reg <= root_next;
        m_reg    <= m_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        diff_reg <= diff_next;
        fnd_reg  <= fnd_next;
        xr_reg   <= xr_next;
        mf_reg   <= mf_next;
        me_reg   <= me_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mf_reg;
    assign m_tdata  = M_TDATA_W'(me_reg);

    // The two shared units are never started in the same cycle.
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mm_cmd.start && tbl_cmd.start))
        else $error("modular unit and table started together");

    // A word that reports no solution carries a zero exponent.
    a_zero_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !mf_reg) |-> (me_reg == '0))
        else $error("exponent not zero without a solution");

    // The giant-step index never runs past m + 1.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GIANT_GET) |-> (i_reg <= m_reg + SQ_W'(1)))
        else $error("giant-step index out of range");

    // Leaving the output state always presents a word.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!mv_reg || m_tready)) |=> mv_reg)
        else $error("result not presented");

endmodule

>>> verif/discrete_log_bsgs_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete logarithm unit testbench
// Sends modulus, base and target words to the unit and checks each result word
// against a known result or a behavioural baby-step giant-step solver. The run
// covers a short directed table and then random queries, most of them built to
// have a solution; the depth is reduced so the per-query table sweep stays short.
// ----------------------------------------------------------------------------
module discrete_log_bsgs_unit_test;

    localparam int MOD_BITS    = 31;
    localparam int TABLE_DEPTH = 4096;
    localparam int S_W         = ((3 * MOD_BITS + 7) / 8) * 8;
    localparam int M_W         = ((MOD_BITS + 7) / 8) * 8;
    localparam int NUM_DIR     = 18;
    localparam int NUM_RANDOM  = 82;
    localparam int IDLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES = 120000;
    localparam int DRAIN       = 300;
    localparam logic [30:0] MAXV = 31'h7FFF_FFFF;

    typedef struct {
        logic [30:0] modulus;
        logic [30:0] base;
        logic [30:0] target;
        bit          known;
        bit          found;
        logic [30:0] exponent;
    } dir_row_t;

    typedef struct {
        bit          found;
        logic [30:0] exponent;
    } solution_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;

    solution_t   pending_solutions[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_request;
    bit          calm;

    bit [30:0]   slot_key   [TABLE_DEPTH];
    int unsigned slot_index [TABLE_DEPTH];
    bit          slot_used  [TABLE_DEPTH];

    discrete_log_bsgs_unit #(
        .MOD_BITS   (MOD_BITS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint unsigned ceil_root(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'h1_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid; else hi = mid;
        end
        if (lo * lo < v) lo++;
        return lo;
    endfunction

    function automatic longint unsigned power_mod(input longint unsigned a,
                                                  input longint unsigned e,
                                                  input longint unsigned p);
        longint unsigned r;
        r = 1 % p;
        while (e != 0) begin
            if (e[0]) r = (r * a) % p;
            a = (a * a) % p;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic int unsigned home_of(input longint unsigned key);
        return int'((key * 64'd2654435761) % TABLE_DEPTH);
    endfunction

    function automatic void store_baby(input longint unsigned key, input int unsigned j);
        int unsigned s;
        s = home_of(key);
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[s] || slot_key[s] == key[30:0]) begin
                slot_used[s]  = 1'b1;
                slot_key[s]   = key[30:0];
                slot_index[s] = j;
                return;
            end
            s = (s + 1 == TABLE_DEPTH) ? 0 : s + 1;
        end
    endfunction

    function automatic bit lookup_baby(input longint unsigned key, output int unsigned j);
        int unsigned s;
        s = home_of(key);
        j = 0;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[s]) return 1'b0;
            if (slot_key[s] == key[30:0]) begin
                j = slot_index[s];
                return 1'b1;
            end
            s = (s + 1 == TABLE_DEPTH) ? 0 : s + 1;
        end
        return 1'b0;
    endfunction

    function automatic solution_t solve_log(input logic [30:0] pm, input logic [30:0] am,
                                            input logic [30:0] bm);
        solution_t       sol;
        longint unsigned p;
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        longint unsigned tmp;
        longint unsigned factor;
        longint unsigned prod;
        int unsigned     j;
        sol.found    = 1'b0;
        sol.exponent = '0;
        p = pm;
        if (p == 0) return sol;
        a = am % p;
        b = bm % p;
        if (a == 0 && b == 0) begin
            sol.found    = 1'b1;
            sol.exponent = 31'(1 % p);
            return sol;
        end
        if (a == 0) return sol;
        for (int k = 0; k < TABLE_DEPTH; k++) slot_used[k] = 1'b0;
        m   = ceil_root(p);
        tmp = b;
        for (longint unsigned i = 0; i <= m; i++) begin
            store_baby(tmp, int'(i));
            tmp = (tmp * a) % p;
        end
        factor = power_mod(a, m, p);
        prod   = 1 % p;
        for (longint unsigned i = 1; i <= m + 1; i++) begin
            prod = (prod * factor) % p;
            if (lookup_baby(prod, j)) begin
                sol.found    = 1'b1;
                sol.exponent = 31'((i * m - j) % p);
                return sol;
            end
        end
        return sol;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_query(input logic [30:0] p, input logic [30:0] a, input logic [30:0] b,
                              input bit known, input solution_t typed);
        int        gap;
        solution_t want;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W - 93){1'b0}}, b, a, p};
        do @(posedge aclk); while (!s_tready);
        want = known ? typed : solve_log(p, a, b);
        pending_solutions = {pending_solutions, want};
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_solutions.size() == 0) begin
                report("unexpected result word, exponent", m_tdata, 0);
            end else begin
                solution_t want;
                want = pending_solutions.pop_front();
                if (m_tuser !== want.found) report("found", m_tuser, want.found);
                if (m_tdata[30:0] !== want.exponent)
                    report("exponent", m_tdata[30:0], want.exponent);
                if (m_tdata[M_W-1:31] !== '0) report("padding", m_tdata, m_tdata[30:0]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout waiting for a word");
            $display("discrete_log_bsgs_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        dir_row_t        rows[NUM_DIR];
        solution_t       none;
        logic [30:0]     p;
        logic [30:0]     a;
        logic [30:0]     b;
        int              pick;
        int              drain;
        none.found    = 1'b0;
        none.exponent = '0;
        mismatches    = 0;
        hold_request  = 1'b0;
        calm          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;

        rows[0]  = '{31'd0,       31'd5,      31'd7,      1'b1, 1'b0, 31'd0};
        rows[1]  = '{31'd1,       31'd123,    31'd456,    1'b1, 1'b1, 31'd0};
        rows[2]  = '{MAXV,        31'd0,      31'd0,      1'b1, 1'b1, 31'd1};
        rows[3]  = '{MAXV,        MAXV,       MAXV,       1'b1, 1'b1, 31'd1};
        rows[4]  = '{31'd2,       31'd0,      31'd1,      1'b1, 1'b0, 31'd0};
        rows[5]  = '{MAXV,        31'd0,      31'd5,      1'b1, 1'b0, 31'd0};
        rows[6]  = '{31'd13,      31'd13,     31'd0,      1'b1, 1'b1, 31'd1};
        rows[7]  = '{31'd13,      31'd26,     MAXV,       1'b1, 1'b0, 31'd0};
        rows[8]  = '{31'd2,       31'd1,      31'd1,      1'b0, 1'b0, 31'd0};
        rows[9]  = '{31'd2,       31'd1,      31'd0,      1'b0, 1'b0, 31'd0};
        rows[10] = '{31'd3,       31'd2,      31'd1,      1'b0, 1'b0, 31'd0};
        rows[11] = '{31'd11,      31'd2,      31'd7,      1'b0, 1'b0, 31'd0};
        rows[12] = '{31'd15,      31'd2,      31'd7,      1'b0, 1'b0, 31'd0};
        rows[13] = '{31'd101,     31'd1,      31'd5,      1'b0, 1'b0, 31'd0};
        rows[14] = '{31'd10007,   31'd5,      31'd3,      1'b0, 1'b0, 31'd0};
        rows[15] = '{31'd65537,   31'd3,      MAXV,       1'b0, 1'b0, 31'd0};
        rows[16] = '{31'd1000003, 31'd2,      31'd12345,  1'b0, 1'b0, 31'd0};
        rows[17] = '{31'd4,       MAXV,       31'd3,      1'b0, 1'b0, 31'd0};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[k]) begin
            solution_t typed;
            typed.found    = rows[k].found;
            typed.exponent = rows[k].exponent;
            send_query(rows[k].modulus, rows[k].base, rows[k].target, rows[k].known, typed);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= 70 && n < 80);
            if (n == 40) hold_request = 1'b1;
            if (n == 60) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_solutions.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) p = 31'($urandom_range(2, 3000));
            else if (pick < 95) p = 31'($urandom_range(2, 70000));
            else p = 31'($urandom_range(2, 300000));
            a = 31'($urandom);
            b = 31'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                p = 31'($urandom);
                if (p < 2) p = 2;
                a = 31'(p * $urandom_range(0, 1));
                if (pick < 4) b = 31'(p * $urandom_range(0, 1));
            end else if (pick < 60) begin
                b = 31'(power_mod(longint'(a) % p, $urandom_range(0, 2 * p), p)
                        + p * $urandom_range(0, 3));
            end
            send_query(p, a, b, 1'b0, none);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_solutions.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < DRAIN) begin
            @(posedge aclk);
            drain++;
        end
        if (mismatches == 0) begin
            $display("discrete_log_bsgs_unit test passed");
        end else begin
            $display("discrete_log_bsgs_unit test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/dlb_pkg.sv
src/dlb_modmul.sv
src/dlb_table.sv
src/discrete_log_bsgs_unit.sv
verif/discrete_log_bsgs_unit_test.sv
